### rtl/pitch_pid_autopilot_core_assert.svh
// Assertion macros shared by the checker of the pitch autopilot core.
// Expects i_clk and i_rst_n to be visible where a macro is used.
`ifndef PITCH_PID_AUTOPILOT_CORE_ASSERT_SVH
`define PITCH_PID_AUTOPILOT_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pitch autopilot check failed");

// The consequent must hold in the cycle after the antecedent.
`define PPA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pitch autopilot check failed");

`endif

### rtl/ppa_pkg.sv
// Shared constants, types and helper functions of the pitch autopilot core.
// No dependencies; imported by the divider, the top level and the checker.
`timescale 1ns / 1ps

package ppa_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int SPEED_RST_INT = 10;

    localparam int DATA_W     = 32;
    localparam int SUM_W      = 48;
    localparam int DT_W       = 17;
    localparam int MS_W       = 31;
    localparam int B_SPLIT_W  = 24;
    localparam int TERM_CAP_W = 40;
    localparam int TOT_W      = 43;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_USER_W = 2;
    localparam int CFG_IDX_W  = 8;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED  = 8'd3;

    localparam logic [DATA_W-1:0] Q32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] Q32_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic done;
        logic ovf;
    } t_div_stat;

    // Signed 32-bit result from a sign and a magnitude; big marks a
    // magnitude of 2^31 or more.
    function automatic logic [DATA_W-1:0] sat_q32(input logic neg, input logic big,
                                                  input logic [DATA_W-1:0] q);
        logic [DATA_W-1:0] res;
        if (neg) begin
            res = big ? Q32_MIN : -q;
        end else begin
            res = big ? Q32_MAX : q;
        end
        return res;
    endfunction

endpackage

### rtl/ppa_div.sv
// Restoring divider, one quotient bit per cycle, for the pitch autopilot core.
// Depends on ppa_pkg for the status struct.
`timescale 1ns / 1ps

module ppa_div
    import ppa_pkg::*;
#(
    parameter int DVD_W = DATA_W + 1 + FRAC_BITS_DEF,
    parameter int Q_W   = DATA_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [Q_W-1:0]   i_divisor,
    output logic [Q_W-1:0]   o_quot,
    output t_div_stat        o_stat
);

    // The part of the dividend above the quotient bits must be narrower
    // than the divisor.
    localparam int UP_W  = DVD_W - Q_W;
    localparam int CNT_W = $clog2(Q_W + 1);

    logic [Q_W-1:0]   r_rem;
    logic [Q_W-1:0]   r_quot;
    logic [Q_W-1:0]   r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic             r_ovf;

    logic [Q_W-1:0]   up_ext;
    logic [Q_W:0]     trial;
    logic [Q_W:0]     diff_c;
    logic             fits;
    logic [Q_W-1:0]   n_rem;

    assign up_ext = {{(Q_W-UP_W){1'b0}}, i_dividend[DVD_W-1:Q_W]};
    assign trial  = {r_rem, r_quot[Q_W-1]};
    assign diff_c = trial - {1'b0, r_dvs};
    assign fits   = !diff_c[Q_W];
    assign n_rem  = fits ? diff_c[Q_W-1:0] : trial[Q_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(Q_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= up_ext;
            r_quot <= i_dividend[Q_W-1:0];
            r_dvs  <= i_divisor;
            r_ovf  <= (up_ext >= i_divisor);
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= {r_quot[Q_W-2:0], fits};
        end
    end

    assign o_quot      = r_quot;
    assign o_stat.done = r_done;
    assign o_stat.ovf  = r_ovf;

endmodule

### rtl/pitch_pid_autopilot_core.sv
// Top level of the fixed-point PID pitch autopilot.
// Depends on ppa_pkg and instantiates the shared divider ppa_div.
`timescale 1ns / 1ps

// The core takes one control tick at a time and answers each with exactly one
// result transaction. An engaged tick runs through a small sequencer that
// reuses one registered 32x32 unsigned multiplier and one restoring divider:
// three squarings for the speed check, the pitch error division, the error
// times time step product, the derivative division and two partial products
// for each of the three gain terms. A full tick, from input transaction to
// result, is dominated by the two 32-step divisions; a tick that skips a
// division (zero horizontal speed or zero time step) is shorter by one
// division. A too-slow tick ends after the speed check and a disengaged
// tick goes from idle straight to its result. The input is ready only while
// the sequencer is idle; a finished result sits in an output register, so
// the next tick can be taken while the previous result waits. Configuration
// writes are always accepted and must be issued only while the core is idle.

module pitch_pid_autopilot_core
    import ppa_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input ticks.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: vel_x [31:0], vel_y [63:32], step_time [80:64], zero [87:81].
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: engaged.
    input  logic                  s_axis_tuser,
    // Results.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: elevator [31:0].
    output logic [DATA_W-1:0]     m_axis_tdata,
    // tuser: command_valid [0], too_slow [1].
    output logic [OUT_USER_W-1:0] m_axis_tuser,
    // Register writes.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [DATA_W-1:0]     i_cfg_data
);

    // Derived sizes of the fixed-point datapath.
    localparam int SHIFT_HI   = B_SPLIT_W - FRAC_BITS;
    localparam int HI_SAT_POS = TERM_CAP_W - SHIFT_HI;
    localparam int LO_W       = DATA_W + B_SPLIT_W - FRAC_BITS;
    localparam int M_W        = ((LO_W > TERM_CAP_W) ? LO_W : TERM_CAP_W) + 1;
    localparam int DVD_W      = DATA_W + 1 + FRAC_BITS;
    localparam logic [MS_W-1:0] MIN_SPEED_RST = MS_W'(SPEED_RST_INT << FRAC_BITS);

    // Sequencer states.
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SQX  = 4'd1;
    localparam logic [3:0] S_SQY  = 4'd2;
    localparam logic [3:0] S_SQM  = 4'd3;
    localparam logic [3:0] S_CMP  = 4'd4;
    localparam logic [3:0] S_EDIV = 4'd5;
    localparam logic [3:0] S_EMUL = 4'd6;
    localparam logic [3:0] S_EINC = 4'd7;
    localparam logic [3:0] S_DDIV = 4'd8;
    localparam logic [3:0] S_TLO  = 4'd9;
    localparam logic [3:0] S_THI  = 4'd10;
    localparam logic [3:0] S_TCMB = 4'd11;
    localparam logic [3:0] S_FIN  = 4'd12;
    localparam logic [3:0] S_DONE = 4'd13;

    // Gain term being accumulated.
    localparam logic [1:0] TERM_P = 2'd0;
    localparam logic [1:0] TERM_I = 2'd1;
    localparam logic [1:0] TERM_D = 2'd2;

    // Control and architectural state.
    logic [3:0]               r_state, n_state;
    logic [1:0]               r_term;
    logic                     r_m_valid;
    logic [DATA_W-1:0]        r_kp, r_ki, r_kd;
    logic [MS_W-1:0]          r_ms;
    logic [SUM_W-1:0]         r_sum, n_sum;
    logic [DATA_W-1:0]        r_last;

    // Datapath registers.
    logic [DATA_W-1:0]        r_ax, r_ay;
    logic                     r_vy_neg;
    logic [DT_W-1:0]          r_dt;
    logic [2*DATA_W-1:0]      r_prod;
    logic [2*DATA_W-1:0]      r_acc;
    logic [DATA_W-1:0]        r_err, n_err;
    logic [DATA_W-1:0]        r_der;
    logic                     r_dneg;
    logic [LO_W-1:0]          r_lo;
    logic [TOT_W-1:0]         r_total;
    logic [DATA_W-1:0]        r_res_elev;
    logic                     r_res_cv, r_res_ts;
    logic [DATA_W-1:0]        r_m_data;
    logic [OUT_USER_W-1:0]    r_m_user;

    // Combinational helpers.
    logic                     in_acc, cfg_wr, out_load;
    logic signed [DATA_W-1:0] in_vx, in_vy;
    logic [DT_W-1:0]          in_dt;
    logic                     in_on;
    logic [DATA_W-1:0]        mul_a, mul_b;
    logic [2*DATA_W-1:0]      prod_c;
    logic                     too_slow_c, ax_zero;
    logic [DATA_W-1:0]        err_mag, err_special;
    logic [SUM_W:0]           inc_w, inc_s, sum_wide;
    logic [DATA_W:0]          diff_c, diff_mag;
    logic                     div_start;
    logic [DVD_W-1:0]         div_dvd;
    logic [DATA_W-1:0]        div_dvs, div_quot;
    t_div_stat                div_stat;
    logic [DATA_W-1:0]        div_sat;
    logic [DATA_W-1:0]        gain_sel, gain_mag;
    logic [SUM_W-1:0]         val_sel, val_mag;
    logic                     t_neg, hi_sat;
    logic [TERM_CAP_W-1:0]    hi_sh;
    logic [M_W-1:0]           m_sum;
    logic [TERM_CAP_W:0]      term_mag;
    logic [TOT_W-1:0]         term_s;
    logic [TOT_W-DATA_W:0]    tot_hi;
    logic [DATA_W-1:0]        elev_c;

    assign in_vx = s_axis_tdata[DATA_W-1:0];
    assign in_vy = s_axis_tdata[2*DATA_W-1:DATA_W];
    assign in_dt = s_axis_tdata[2*DATA_W+DT_W-1:2*DATA_W];
    assign in_on = s_axis_tuser;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign cfg_wr        = i_cfg_valid;
    assign out_load      = (r_state == S_DONE) && (!r_m_valid || m_axis_tready);

    // Speed check and pitch error.
    assign too_slow_c  = (r_acc < r_prod);
    assign ax_zero     = (r_ax == '0);
    assign err_special = r_vy_neg ? Q32_MIN : ((r_ay == '0) ? '0 : Q32_MAX);
    assign err_mag     = r_err[DATA_W-1] ? -r_err : r_err;
    assign div_sat     = sat_q32((r_state == S_EDIV) ? r_vy_neg : r_dneg,
                                 div_stat.ovf || div_quot[DATA_W-1], div_quot);
    assign n_err       = div_sat;

    // Integral update: the product |err|*dt is below 2^48, so the shifted
    // increment is exact; the sum saturates to 48 bits.
    assign inc_w    = (SUM_W+1)'(r_prod[SUM_W-1:FRAC_BITS]);
    assign inc_s    = r_err[DATA_W-1] ? -inc_w : inc_w;
    assign sum_wide = {r_sum[SUM_W-1], r_sum} + inc_s;
    always_comb begin
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            n_sum = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            n_sum = sum_wide[SUM_W-1:0];
        end
    end

    // Change of error for the derivative, 33 bits wide.
    assign diff_c   = {r_err[DATA_W-1], r_err} - {r_last[DATA_W-1], r_last};
    assign diff_mag = diff_c[DATA_W] ? -diff_c : diff_c;

    // The divider serves the error quotient and the derivative quotient.
    assign div_start = ((r_state == S_CMP) && !too_slow_c && !ax_zero) ||
                       ((r_state == S_EINC) && (r_dt != '0));
    assign div_dvd   = (r_state == S_CMP) ? (DVD_W'(r_ay) << FRAC_BITS)
                                          : (DVD_W'(diff_mag) << FRAC_BITS);
    assign div_dvs   = (r_state == S_CMP) ? r_ax : DATA_W'(r_dt);

    ppa_div #(
        .DVD_W (DVD_W),
        .Q_W   (DATA_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_quot     (div_quot),
        .o_stat     (div_stat)
    );

    // Operands of the current gain term.
    always_comb begin
        unique case (r_term)
            TERM_P: begin
                gain_sel = r_kp;
                val_sel  = {{(SUM_W-DATA_W){r_err[DATA_W-1]}}, r_err};
            end
            TERM_I: begin
                gain_sel = r_ki;
                val_sel  = r_sum;
            end
            TERM_D: begin
                gain_sel = r_kd;
                val_sel  = {{(SUM_W-DATA_W){r_der[DATA_W-1]}}, r_der};
            end
            default: begin
                gain_sel = '0;
                val_sel  = '0;
            end
        endcase
    end

    assign gain_mag = gain_sel[DATA_W-1] ? -gain_sel : gain_sel;
    assign val_mag  = val_sel[SUM_W-1] ? -val_sel : val_sel;
    assign t_neg    = gain_sel[DATA_W-1] ^ val_sel[SUM_W-1];

    // Shared multiplier operand selection; the product is registered.
    always_comb begin
        unique case (r_state)
            S_SQX: begin
                mul_a = r_ax;
                mul_b = r_ax;
            end
            S_SQY: begin
                mul_a = r_ay;
                mul_b = r_ay;
            end
            S_SQM: begin
                mul_a = DATA_W'(r_ms);
                mul_b = DATA_W'(r_ms);
            end
            S_EMUL: begin
                mul_a = err_mag;
                mul_b = DATA_W'(r_dt);
            end
            S_TLO: begin
                mul_a = gain_mag;
                mul_b = DATA_W'(val_mag[B_SPLIT_W-1:0]);
            end
            S_THI: begin
                mul_a = gain_mag;
                mul_b = DATA_W'(val_mag[SUM_W-1:B_SPLIT_W]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_c = mul_a * mul_b;

    // Recombine the two partial products of a gain term. The magnitude is
    // capped at 2^40, either because the high product alone is too large
    // or because the recombined sum exceeds the cap.
    assign hi_sat   = |r_prod[2*DATA_W-1:HI_SAT_POS];
    assign hi_sh    = TERM_CAP_W'(r_prod[HI_SAT_POS-1:0]) << SHIFT_HI;
    assign m_sum    = M_W'(hi_sh) + M_W'(r_lo);
    assign term_mag = (hi_sat || (m_sum > (M_W'(1) << TERM_CAP_W)))
                      ? ((TERM_CAP_W+1)'(1) << TERM_CAP_W) : m_sum[TERM_CAP_W:0];
    assign term_s   = t_neg ? -TOT_W'(term_mag) : TOT_W'(term_mag);

    // Final saturation of the summed terms to 32 bits.
    assign tot_hi = r_total[TOT_W-1:DATA_W-1];
    assign elev_c = ((&tot_hi) || !(|tot_hi)) ? r_total[DATA_W-1:0]
                  : (r_total[TOT_W-1] ? Q32_MIN : Q32_MAX);

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_acc) n_state = in_on ? S_SQX : S_DONE;
            S_SQX:  n_state = S_SQY;
            S_SQY:  n_state = S_SQM;
            S_SQM:  n_state = S_CMP;
            S_CMP: begin
                if (too_slow_c) begin
                    n_state = S_DONE;
                end else begin
                    n_state = ax_zero ? S_EMUL : S_EDIV;
                end
            end
            S_EDIV: if (div_stat.done) n_state = S_EMUL;
            S_EMUL: n_state = S_EINC;
            S_EINC: n_state = (r_dt == '0) ? S_TLO : S_DDIV;
            S_DDIV: if (div_stat.done) n_state = S_TLO;
            S_TLO:  n_state = S_THI;
            S_THI:  n_state = S_TCMB;
            S_TCMB: n_state = (r_term == TERM_D) ? S_FIN : S_TLO;
            S_FIN:  n_state = S_DONE;
            S_DONE: if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_term    <= TERM_P;
            r_m_valid <= 1'b0;
            r_kp      <= '0;
            r_ki      <= '0;
            r_kd      <= '0;
            r_ms      <= MIN_SPEED_RST;
            r_sum     <= '0;
            r_last    <= '0;
        end else begin
            r_state <= n_state;

            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            if (cfg_wr) begin
                unique case (i_cfg_index)
                    REG_GAIN_PROP:  r_kp <= i_cfg_data;
                    REG_GAIN_INTEG: r_ki <= i_cfg_data;
                    REG_GAIN_DERIV: r_kd <= i_cfg_data;
                    REG_MIN_SPEED:  r_ms <= i_cfg_data[MS_W-1:0];
                    default: ;
                endcase
            end

            // A disengaged tick forgets the integral and the previous error.
            if ((r_state == S_IDLE) && in_acc && !in_on) begin
                r_sum  <= '0;
                r_last <= '0;
            end else if (r_state == S_EINC) begin
                r_sum  <= n_sum;
                r_last <= r_err;
            end

            if (r_state == S_EMUL) begin
                r_term <= TERM_P;
            end else if ((r_state == S_TCMB) && (r_term != TERM_D)) begin
                r_term <= r_term + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= prod_c;

        if ((r_state == S_IDLE) && in_acc) begin
            r_ax       <= in_vx[DATA_W-1] ? -in_vx : in_vx;
            r_ay       <= in_vy[DATA_W-1] ? -in_vy : in_vy;
            r_vy_neg   <= in_vy[DATA_W-1];
            r_dt       <= in_dt;
            r_res_elev <= '0;
            r_res_cv   <= 1'b0;
            r_res_ts   <= 1'b0;
        end

        if (r_state == S_SQY) begin
            r_acc <= r_prod;
        end else if (r_state == S_SQM) begin
            r_acc <= r_acc + r_prod;
        end

        if (r_state == S_CMP) begin
            r_res_elev <= '0;
            r_res_cv   <= 1'b1;
            r_res_ts   <= too_slow_c;
            r_err      <= err_special;
        end else if ((r_state == S_EDIV) && div_stat.done) begin
            r_err <= n_err;
        end

        if (r_state == S_EMUL) begin
            r_total <= '0;
        end else if (r_state == S_TCMB) begin
            r_total <= r_total + term_s;
        end

        if (r_state == S_EINC) begin
            r_der  <= '0;
            r_dneg <= diff_c[DATA_W];
        end else if ((r_state == S_DDIV) && div_stat.done) begin
            r_der <= div_sat;
        end

        if (r_state == S_THI) begin
            r_lo <= r_prod[LO_W+FRAC_BITS-1:FRAC_BITS];
        end

        if (r_state == S_FIN) begin
            r_res_elev <= elev_c;
        end

        if (out_load) begin
            r_m_data <= r_res_elev;
            r_m_user <= {r_res_ts, r_res_cv};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

endmodule

### rtl/ppa_checker.sv
// Port-level checks of the pitch autopilot core, bound to the top level.
// Depends on ppa_pkg and the assertion macros in the shared header.
`timescale 1ns / 1ps

`include "pitch_pid_autopilot_core_assert.svh"

module ppa_checker
    import ppa_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [DATA_W-1:0]     m_axis_tdata,
    input logic [OUT_USER_W-1:0] m_axis_tuser
);

    // After taking a tick the sequencer is busy and refuses the next one.
    `PPA_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // A new result appears exactly as the sequencer returns to idle.
    `PPA_ASSERT_SAME(a_result_with_idle, $rose(m_axis_tvalid), s_axis_tready)

    // Without a command the elevator value is zero; a too-slow result is a
    // written zero command.
    `PPA_ASSERT_SAME(a_no_cmd_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == '0)
    `PPA_ASSERT_SAME(a_slow_zero, m_axis_tvalid && m_axis_tuser[1],
                     m_axis_tuser[0] && (m_axis_tdata == '0))

    // A stalled result holds.
    `PPA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                     m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind pitch_pid_autopilot_core ppa_checker u_ppa_checker (.*);
